FILE: hw/rtl/elrgb_pkg.sv
// Shared constants, types and color stop tables for the elevation colormap.
package elrgb_pkg;

    localparam int ELEV_W            = 24;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_IDX_W         = 2;
    localparam int SEG_MAX           = 4;
    localparam int X_W               = 16;   // scaled channel numerator before /2W
    localparam int RECIP_W           = 19;
    localparam int RECIP_SHIFT       = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_ELEV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ELEV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCHEME   = 2'd2;

    localparam logic [1:0] SCHEME_TERRAIN = 2'd0;
    localparam logic [1:0] SCHEME_HYPSO   = 2'd1;
    localparam logic [1:0] SCHEME_GRAY    = 2'd2;
    localparam logic [1:0] SCHEME_RAINBOW = 2'd3;

    localparam logic [ELEV_W-1:0] MIN_ELEV_RST = 24'd0;
    localparam logic [ELEV_W-1:0] MAX_ELEV_RST = 24'd8000;
    localparam logic [1:0]        SCHEME_RST   = SCHEME_TERRAIN;

    typedef struct packed {
        logic invalid;
        logic sat_one;
    } div_flags_t;

    // breakpoints in hundredths, colors in tenths, index 0 is red
    typedef struct packed {
        logic [6:0]      b0;
        logic [6:0]      b1;
        logic [2:0][3:0] c0;
        logic [2:0][3:0] c1;
    } seg_t;

    function automatic seg_t mk_seg(input logic [6:0] b0, input logic [6:0] b1,
                                    input logic [3:0] r0, input logic [3:0] g0,
                                    input logic [3:0] u0, input logic [3:0] r1,
                                    input logic [3:0] g1, input logic [3:0] u1);
        seg_t s;
        s.b0 = b0;
        s.b1 = b1;
        s.c0 = {u0, g0, r0};
        s.c1 = {u1, g1, r1};
        return s;
    endfunction

    function automatic logic [1:0] seg_last(input logic [1:0] scheme);
        logic [1:0] last;
        case (scheme)
            SCHEME_TERRAIN: last = 2'd2;
            SCHEME_HYPSO:   last = 2'd2;
            SCHEME_GRAY:    last = 2'd0;
            default:        last = 2'd3;
        endcase
        return last;
    endfunction

    function automatic seg_t seg_entry(input logic [1:0] scheme, input logic [1:0] k);
        seg_t s;
        s = mk_seg(7'd0, 7'd100, 4'd0, 4'd0, 4'd0, 4'd10, 4'd10, 4'd10);
        case (scheme)
            SCHEME_TERRAIN: begin
                case (k)
                    2'd0:    s = mk_seg(7'd0, 7'd30, 4'd6, 4'd4, 4'd2, 4'd2, 4'd6, 4'd2);
                    2'd1:    s = mk_seg(7'd30, 7'd70, 4'd2, 4'd6, 4'd2, 4'd5, 4'd5, 4'd5);
                    default: s = mk_seg(7'd70, 7'd100, 4'd5, 4'd5, 4'd5, 4'd10, 4'd10, 4'd10);
                endcase
            end
            SCHEME_HYPSO: begin
                case (k)
                    2'd0:    s = mk_seg(7'd0, 7'd25, 4'd0, 4'd5, 4'd0, 4'd10, 4'd10, 4'd0);
                    2'd1:    s = mk_seg(7'd25, 7'd75, 4'd10, 4'd10, 4'd0, 4'd6, 4'd3, 4'd0);
                    default: s = mk_seg(7'd75, 7'd100, 4'd6, 4'd3, 4'd0, 4'd10, 4'd10, 4'd10);
                endcase
            end
            SCHEME_RAINBOW: begin
                case (k)
                    2'd0:    s = mk_seg(7'd0, 7'd25, 4'd0, 4'd0, 4'd10, 4'd0, 4'd10, 4'd10);
                    2'd1:    s = mk_seg(7'd25, 7'd50, 4'd0, 4'd10, 4'd10, 4'd0, 4'd10, 4'd0);
                    2'd2:    s = mk_seg(7'd50, 7'd75, 4'd0, 4'd10, 4'd0, 4'd10, 4'd10, 4'd0);
                    default: s = mk_seg(7'd75, 7'd100, 4'd10, 4'd10, 4'd0, 4'd10, 4'd0, 4'd0);
                endcase
            end
            default: s = mk_seg(7'd0, 7'd100, 4'd0, 4'd0, 4'd0, 4'd10, 4'd10, 4'd10);
        endcase
        return s;
    endfunction

    // floor(2^RECIP_SHIFT / (2*width)) for the segment widths in the tables
    function automatic logic [RECIP_W-1:0] seg_recip(input logic [6:0] width);
        logic [RECIP_W-1:0] m;
        case (width)
            7'd25:   m = 19'd335544;
            7'd30:   m = 19'd279620;
            7'd40:   m = 19'd209715;
            7'd50:   m = 19'd167772;
            7'd100:  m = 19'd83886;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/elrgb_div_cell.sv
// One cell of the normalizing divider chain: resolves one quotient bit per beat.
module elrgb_div_cell #(
    parameter int FRACTION_BITS = elrgb_pkg::FRACTION_BITS_DEF,
    parameter int STEP          = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [elrgb_pkg::ELEV_W-1:0]  in_rem,
    input  logic [FRACTION_BITS-1:0]      in_quo,
    input  elrgb_pkg::div_flags_t         in_flags,
    input  logic [elrgb_pkg::ELEV_W-1:0]  divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [elrgb_pkg::ELEV_W-1:0]  out_rem,
    output logic [FRACTION_BITS-1:0]      out_quo,
    output elrgb_pkg::div_flags_t         out_flags
);

    localparam int EW  = elrgb_pkg::ELEV_W;
    localparam int BIT = FRACTION_BITS - 1 - STEP;

    logic                     vld_reg;
    logic [EW-1:0]            rem_reg, rem_next;
    logic [FRACTION_BITS-1:0] quo_reg, quo_next;
    elrgb_pkg::div_flags_t    flags_reg;
    logic [EW:0]              dbl;
    logic                     take;

    assign in_ready = !vld_reg || out_ready;

    always_comb begin
        dbl      = {in_rem, 1'b0};
        take     = dbl >= {1'b0, divisor};
        rem_next = take ? EW'(dbl - {1'b0, divisor}) : dbl[EW-1:0];
        quo_next = in_quo;
        quo_next[BIT] = take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = vld_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_flags = flags_reg;

    // saturated or empty-range beats carry a zero remainder and quotient
    a_forced_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg && (flags_reg.invalid || flags_reg.sat_one) |->
            rem_reg == '0 && quo_reg == '0)
        else $error("forced beat picked up quotient bits");

endmodule

FILE: hw/rtl/elrgb_ramp.sv
// Color ramp pipeline: segment select, lerp per channel and rounding to 8 bits.
module elrgb_ramp #(
    parameter int FRACTION_BITS = elrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FRACTION_BITS:0] in_norm,
    input  logic                   in_invalid,
    input  logic [1:0]             scheme,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0][7:0]        out_rgb,
    output logic                   out_invalid
);

    localparam int NSTG = 6;
    localparam int NW   = FRACTION_BITS + 7;
    localparam int PW   = FRACTION_BITS + 18;
    localparam int XW   = elrgb_pkg::X_W;
    localparam int MW   = elrgb_pkg::RECIP_W;
    localparam int QW   = 9;
    localparam int SH   = elrgb_pkg::RECIP_SHIFT;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] vin;

    always_comb begin
        rdy[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];
    assign vin      = {vld_reg[NSTG-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vin[i];
                end
            end
        end
    end

    // stage 0: n * 100
    logic [NW-1:0] n100_reg;
    logic          inv0_reg;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            n100_reg <= NW'(in_norm) * NW'(7'd100);
            inv0_reg <= in_invalid;
        end
    end

    // stage 1: segment select and per-channel constants
    logic [1:0]               last, sel;
    elrgb_pkg::seg_t          cand, seg;
    logic [6:0]               width;
    logic [NW-1:0]            t_next, t_reg;
    logic signed [10:0]       dc_w;
    logic [2:0][10:0]         k_next, k_reg;
    logic [2:0][XW-1:0]       base_next, base_reg;
    logic [7:0]               den_next, den_reg;
    logic [MW-1:0]            m_next, m_reg;
    logic                     inv1_reg;

    always_comb begin
        last = elrgb_pkg::seg_last(scheme);
        sel  = last;
        cand = elrgb_pkg::seg_entry(scheme, 2'd0);
        for (int c = elrgb_pkg::SEG_MAX - 1; c >= 0; c--) begin
            cand = elrgb_pkg::seg_entry(scheme, 2'(c));
            if (2'(c) <= last && n100_reg < (NW'(cand.b1) << FRACTION_BITS)) begin
                sel = 2'(c);
            end
        end
        seg      = elrgb_pkg::seg_entry(scheme, sel);
        width    = seg.b1 - seg.b0;
        t_next   = n100_reg - (NW'(seg.b0) << FRACTION_BITS);
        den_next = {width, 1'b0};
        m_next   = elrgb_pkg::seg_recip(width);
        dc_w     = '0;
        for (int ch = 0; ch < 3; ch++) begin
            dc_w          = $signed({7'd0, seg.c1[ch]}) - $signed({7'd0, seg.c0[ch]});
            k_next[ch]    = dc_w * 11'sd51;
            base_next[ch] = XW'(width) * (XW'(seg.c0[ch]) * XW'(8'd51) + XW'(1'b1));
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            t_reg    <= t_next;
            k_reg    <= k_next;
            base_reg <= base_next;
            den_reg  <= den_next;
            m_reg    <= m_next;
            inv1_reg <= inv0_reg;
        end
    end

    // stage 2: slope times position
    logic signed [PW-1:0]     p_next [3];
    logic signed [PW-1:0]     p_reg [3];
    logic signed [NW:0]       t_s;
    logic [2:0][XW-1:0]       base2_reg;
    logic [7:0]               den2_reg;
    logic [MW-1:0]            m2_reg;
    logic                     inv2_reg;

    always_comb begin
        t_s = $signed({1'b0, t_reg});
        for (int ch = 0; ch < 3; ch++) begin
            p_next[ch] = PW'($signed(k_reg[ch])) * PW'(t_s);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            p_reg     <= p_next;
            base2_reg <= base_reg;
            den2_reg  <= den_reg;
            m2_reg    <= m_reg;
            inv2_reg  <= inv1_reg;
        end
    end

    // stage 3: add the start color and the rounding half, drop fraction bits
    logic signed [PW-1:0] z [3];
    logic [2:0][XW-1:0]   x_next, x_reg;
    logic [7:0]           den3_reg;
    logic [MW-1:0]        m3_reg;
    logic                 inv3_reg;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            z[ch]      = p_reg[ch] + $signed(PW'(base2_reg[ch]) << FRACTION_BITS);
            x_next[ch] = z[ch][FRACTION_BITS +: XW];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            x_reg    <= x_next;
            den3_reg <= den2_reg;
            m3_reg   <= m2_reg;
            inv3_reg <= inv2_reg;
        end
    end

    // stage 4: quotient estimate by reciprocal, at most one low
    logic [XW+MW-1:0]   prod [3];
    logic [2:0][QW-1:0] qe_next, qe_reg;
    logic [2:0][XW-1:0] x4_reg;
    logic [7:0]         den4_reg;
    logic               inv4_reg;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch]    = (XW+MW)'(x_reg[ch]) * (XW+MW)'(m3_reg);
            qe_next[ch] = prod[ch][SH +: QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            qe_reg   <= qe_next;
            x4_reg   <= x_reg;
            den4_reg <= den3_reg;
            inv4_reg <= inv3_reg;
        end
    end

    // stage 5: correction step and output register
    logic [2:0][XW:0]   fix_rem;
    logic [2:0][QW-1:0] q_fix;
    logic [2:0][7:0]    rgb_next, rgb_reg;
    logic               est_ok;
    logic               inv5_reg;

    always_comb begin
        est_ok = 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
            fix_rem[ch] = (XW+1)'(x4_reg[ch]) - (XW+1)'(qe_reg[ch]) * (XW+1)'(den4_reg);
            q_fix[ch]   = (fix_rem[ch] >= (XW+1)'(den4_reg)) ? qe_reg[ch] + QW'(1'b1)
                                                              : qe_reg[ch];
            rgb_next[ch] = q_fix[ch][8] ? 8'hFF : q_fix[ch][7:0];
            if (fix_rem[ch] >= ((XW+1)'(den4_reg) << 1)) begin
                est_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            rgb_reg  <= rgb_next;
            inv5_reg <= inv4_reg;
        end
    end

    assign out_valid   = vld_reg[NSTG-1];
    assign out_rgb     = rgb_reg;
    assign out_invalid = inv5_reg;

    a_pos_in_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] |-> t_reg <= (NW'(den_reg) << (FRACTION_BITS - 1)))
        else $error("ramp position beyond segment width");

    a_estimate_close: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[4] |-> est_ok)
        else $error("reciprocal estimate more than one below quotient");

endmodule

FILE: hw/rtl/elevation_to_rgb_colormap_top.sv
// Top level of the elevation to RGB colormap: config registers, divider chain, ramp.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata, one signed Q.4 elevation per
// beat. Each accepted beat yields exactly one color beat on m_tvalid/m_tready,
// with red, green and blue in m_tdata and the empty-range flag in m_tuser.
// Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 is
// the minimum elevation, 1 the maximum, 2 the color scheme; other indexes are
// dropped. cfg_ready is always high; write only while no beat is in flight.
// The path is one input stage, one divider cell per quotient bit and six ramp
// stages. Throughput is one beat per cycle while m_tready stays high, set by the
// divider chain resolving one bit per cell per cycle.
// Every stage has its own valid bit, so bubbles close up and the block keeps
// taking beats while a finished color waits. When m_tready is low the chain
// fills and s_tready drops only once no stage is empty.
// Reset clears all valid bits and loads min 0, max 8000 (500.0), terrain.
module elevation_to_rgb_colormap_top #(
    parameter int FRACTION_BITS = elrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // [23:0] elevation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // [7:0] red, [15:8] green,
                                                           // [23:16] blue
    output logic                                m_tuser,   // [0] range_invalid
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [elrgb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [elrgb_pkg::ELEV_W-1:0]        cfg_data
);

    localparam int EW = elrgb_pkg::ELEV_W;

    // configuration registers
    logic [EW-1:0] min_reg, max_reg;
    logic [1:0]    scheme_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg    <= elrgb_pkg::MIN_ELEV_RST;
            max_reg    <= elrgb_pkg::MAX_ELEV_RST;
            scheme_reg <= elrgb_pkg::SCHEME_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                elrgb_pkg::REG_MIN_ELEV: min_reg    <= cfg_data;
                elrgb_pkg::REG_MAX_ELEV: max_reg    <= cfg_data;
                elrgb_pkg::REG_SCHEME:   scheme_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic          range_bad;
    logic [EW:0]   span;
    logic [EW-1:0] divisor;

    always_comb begin
        range_bad = $signed(max_reg) <= $signed(min_reg);
        span      = {max_reg[EW-1], max_reg} - {min_reg[EW-1], min_reg};
        divisor   = range_bad ? '1 : span[EW-1:0];
    end

    // input stage: offset from minimum and compare against maximum
    logic          in_vld_reg;
    logic [EW:0]   d_reg;
    logic          ge_reg;
    logic          ch0_ready;

    assign s_tready = !in_vld_reg || ch0_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            d_reg  <= {s_tdata[EW-1], s_tdata[EW-1:0]} - {min_reg[EW-1], min_reg};
            ge_reg <= $signed(s_tdata[EW-1:0]) >= $signed(max_reg);
        end
    end

    logic                  nonpos;
    logic                  force0;
    elrgb_pkg::div_flags_t flags0;
    logic [EW-1:0]         rem0;

    always_comb begin
        nonpos         = d_reg[EW] || (d_reg == '0);
        force0         = range_bad || nonpos || ge_reg;
        rem0           = force0 ? '0 : d_reg[EW-1:0];
        flags0.invalid = range_bad;
        flags0.sat_one = !range_bad && !nonpos && ge_reg;
    end

    // divider chain, one cell per quotient bit
    logic                     ch_valid [FRACTION_BITS+1];
    logic                     ch_ready [FRACTION_BITS+1];
    logic [EW-1:0]            ch_rem   [FRACTION_BITS+1];
    logic [FRACTION_BITS-1:0] ch_quo   [FRACTION_BITS+1];
    elrgb_pkg::div_flags_t    ch_flags [FRACTION_BITS+1];

    assign ch_valid[0] = in_vld_reg;
    assign ch_rem[0]   = rem0;
    assign ch_quo[0]   = '0;
    assign ch_flags[0] = flags0;
    assign ch0_ready   = ch_ready[0];

    for (genvar g = 0; g < FRACTION_BITS; g++) begin : g_cell
        elrgb_div_cell #(
            .FRACTION_BITS (FRACTION_BITS),
            .STEP          (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (ch_valid[g]),
            .in_ready  (ch_ready[g]),
            .in_rem    (ch_rem[g]),
            .in_quo    (ch_quo[g]),
            .in_flags  (ch_flags[g]),
            .divisor   (divisor),
            .out_valid (ch_valid[g+1]),
            .out_ready (ch_ready[g+1]),
            .out_rem   (ch_rem[g+1]),
            .out_quo   (ch_quo[g+1]),
            .out_flags (ch_flags[g+1])
        );
    end

    // remainder of the last cell is not needed
    logic [EW-1:0] tail_rem;
    assign tail_rem = ch_rem[FRACTION_BITS];

    // saturated beats come out of the chain with a zero quotient
    logic [FRACTION_BITS:0] norm;
    assign norm = {ch_flags[FRACTION_BITS].sat_one, ch_quo[FRACTION_BITS]};

    logic [2:0][7:0] rgb;
    logic            rgb_inv;

    elrgb_ramp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ramp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (ch_valid[FRACTION_BITS]),
        .in_ready    (ch_ready[FRACTION_BITS]),
        .in_norm     (norm),
        .in_invalid  (ch_flags[FRACTION_BITS].invalid),
        .scheme      (scheme_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_rgb     (rgb),
        .out_invalid (rgb_inv)
    );

    assign m_tdata = rgb;
    assign m_tuser = rgb_inv;

    a_tail_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ch_valid[FRACTION_BITS] && !ch_flags[FRACTION_BITS].invalid &&
        $stable(divisor) |-> tail_rem < divisor || tail_rem == '0)
        else $error("divider remainder not below divisor");

endmodule
